/* rtl/core/outbound_address_translation_unit_assert.svh */
// Assertion macros for the outbound address translation unit.
`ifndef OUTBOUND_ADDRESS_TRANSLATION_UNIT_ASSERT_SVH
`define OUTBOUND_ADDRESS_TRANSLATION_UNIT_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define OATU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define OATU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/oatu_pkg.sv */
// Types, codes and helper functions shared by the address translation unit.
package oatu_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_XLATE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_BASE_SIZE = 2'd0,
        REG_ENABLE    = 2'd1,
        REG_TARGET_HI = 2'd2,
        REG_TARGET_LO = 2'd3
    } reg_sel_t;

    localparam int BASE_W      = 16;
    localparam int SIZE_CODE_W = 5;
    localparam int ENABLE_POS  = 31;
    localparam int LOG2_W      = 7;

    typedef struct packed {
        cmd_t        command;
        logic [2:0]  window_select;
        reg_sel_t    register_select;
        logic [31:0] write_data;
        logic [31:0] inbound_addr;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [63:0] translated_addr;
        logic        hit;
        logic [2:0]  hit_window;
    } rsp_t;

    typedef struct packed {
        logic                   enable;
        logic [BASE_W-1:0]      base;
        logic [SIZE_CODE_W-1:0] size_code;
        logic [31:0]            target_hi;
        logic [31:0]            target_lo;
    } window_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  hit_window;
        logic [63:0] translated_addr;
    } match_t;

    // Offset mask of a window of 2^lg bytes; anything of 32 or more covers all.
    function automatic logic [31:0] offset_mask(input logic [LOG2_W-1:0] lg);
        logic [32:0] one_hot;
        begin
            one_hot = 33'd1 << lg;
            if (lg >= LOG2_W'(32))
            begin
                offset_mask = '1;
            end
            else
            begin
                offset_mask = 32'(one_hot - 33'd1);
            end
        end
    endfunction

endpackage

/* rtl/core/oatu_windows.sv */
// Window register file with register write and read access.
module oatu_windows #(
    parameter int WINDOW_COUNT = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic                                  rd_en,
    input  logic [2:0]                            window_select,
    input  oatu_pkg::reg_sel_t                    register_select,
    input  logic [31:0]                           write_data,
    output logic [31:0]                           read_data,
    output oatu_pkg::window_t [WINDOW_COUNT-1:0]  windows
);

    localparam int IDX_W = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;

    oatu_pkg::window_t [WINDOW_COUNT-1:0] windows_reg;
    logic [IDX_W-1:0]                     widx;
    logic                                 win_valid;
    oatu_pkg::window_t                    sel_win;

    assign widx      = IDX_W'(window_select);
    assign win_valid = {29'd0, window_select} < 32'(WINDOW_COUNT);
    assign sel_win   = windows_reg[widx];
    assign windows   = windows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            windows_reg <= '0;
        end
        else if (wr_en && win_valid)
        begin
            unique case (register_select)
                oatu_pkg::REG_BASE_SIZE:
                begin
                    windows_reg[widx].base      <= write_data[31:16];
                    windows_reg[widx].size_code <= write_data[oatu_pkg::SIZE_CODE_W-1:0];
                end
                oatu_pkg::REG_ENABLE:
                begin
                    windows_reg[widx].enable <= write_data[oatu_pkg::ENABLE_POS];
                end
                oatu_pkg::REG_TARGET_HI:
                begin
                    windows_reg[widx].target_hi <= write_data;
                end
                default:
                begin
                    windows_reg[widx].target_lo <= write_data;
                end
            endcase
        end
    end

    // Reserved bits read back as zero.
    always_comb
    begin
        read_data = '0;
        if (rd_en && win_valid)
        begin
            unique case (register_select)
                oatu_pkg::REG_BASE_SIZE: read_data = {sel_win.base, 11'd0, sel_win.size_code};
                oatu_pkg::REG_ENABLE:    read_data = {sel_win.enable, 31'd0};
                oatu_pkg::REG_TARGET_HI: read_data = sel_win.target_hi;
                default:                 read_data = sel_win.target_lo;
            endcase
        end
    end

endmodule

/* rtl/core/oatu_match.sv */
// Parallel window compare with lowest-index priority and address assembly.
module oatu_match #(
    parameter int WINDOW_COUNT    = 8,
    parameter int MIN_WINDOW_LOG2 = 16
) (
    input  oatu_pkg::window_t [WINDOW_COUNT-1:0] windows,
    input  logic [31:0]                          inbound_addr,
    output oatu_pkg::match_t                     result
);

    logic [WINDOW_COUNT-1:0] match_vec;
    logic [WINDOW_COUNT-1:0] sel_vec;
    logic [31:0]             mask [WINDOW_COUNT];
    logic [63:0]             xlat [WINDOW_COUNT];

    always_comb
    begin
        for (int i = 0; i < WINDOW_COUNT; i++)
        begin
            mask[i] = oatu_pkg::offset_mask(oatu_pkg::LOG2_W'(MIN_WINDOW_LOG2)
                                            + oatu_pkg::LOG2_W'(windows[i].size_code));
            match_vec[i] = windows[i].enable
                && ((inbound_addr & ~mask[i]) == ({windows[i].base, 16'd0} & ~mask[i]));
            xlat[i] = {windows[i].target_hi,
                       (windows[i].target_lo & ~mask[i]) | (inbound_addr & mask[i])};
        end
    end

    // One-hot select of the lowest matching window.
    always_comb
    begin
        logic lower_hit;
        lower_hit = 1'b0;
        for (int i = 0; i < WINDOW_COUNT; i++)
        begin
            sel_vec[i] = match_vec[i] && !lower_hit;
            lower_hit  = lower_hit || match_vec[i];
        end
    end

    always_comb
    begin
        result = '0;
        result.hit = |match_vec;
        for (int i = 0; i < WINDOW_COUNT; i++)
        begin
            if (sel_vec[i])
            begin
                result.hit_window      = result.hit_window | 3'(i);
                result.translated_addr = result.translated_addr | xlat[i];
            end
        end
    end

endmodule

/* rtl/core/outbound_address_translation_unit.sv */
// Top level of the outbound address translation unit.
//
// A request arrives on req (valid/stall) and carries a command: a register
// write, a register read or the translation of an inbound address. Each
// window has a base and size register, an enable register and a 64-bit
// target split into upper and lower words. One response leaves on rsp
// (valid/stall) for every request, in request order.
//
// The request is captured in an input register; from there the window
// registers are written or read, or all enabled windows are compared in
// parallel and the lowest-numbered match is chosen, and the response is
// loaded into the output register. One request is taken every cycle while
// the receiver keeps up.
//
// Reset clears every window register, so all windows start disabled and a
// translation misses. When the receiver stalls, the response holds in the
// output register, the input register holds its request, and req_stall is
// raised while both registers are full and rsp_stall stays high.
module outbound_address_translation_unit #(
    parameter int WINDOW_COUNT    = 8,
    parameter int MIN_WINDOW_LOG2 = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  oatu_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output oatu_pkg::rsp_t rsp
);

    `include "outbound_address_translation_unit_assert.svh"

    // Input stage and output stage registers.
    logic                                 req_valid_reg;
    oatu_pkg::req_t                       req_reg;
    logic                                 rsp_valid_reg;
    oatu_pkg::rsp_t                       rsp_reg;
    oatu_pkg::rsp_t                       rsp_next;

    logic                                 advance;
    logic                                 wr_en;
    logic                                 rd_en;
    logic [31:0]                          read_data;
    oatu_pkg::window_t [WINDOW_COUNT-1:0] windows;
    oatu_pkg::match_t                     match;

    // The input stage moves on whenever the output register is free or
    // is being emptied in this cycle.
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = req_valid_reg && !advance;

    // Register writes take effect as the request leaves the input stage, so
    // the following request already sees them.
    assign wr_en = req_valid_reg && advance && (req_reg.command == oatu_pkg::CMD_WRITE);
    assign rd_en = req_reg.command == oatu_pkg::CMD_READ;

    oatu_windows #(
        .WINDOW_COUNT (WINDOW_COUNT)
    ) u_windows (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .rd_en           (rd_en),
        .window_select   (req_reg.window_select),
        .register_select (req_reg.register_select),
        .write_data      (req_reg.write_data),
        .read_data       (read_data),
        .windows         (windows)
    );

    oatu_match #(
        .WINDOW_COUNT    (WINDOW_COUNT),
        .MIN_WINDOW_LOG2 (MIN_WINDOW_LOG2)
    ) u_match (
        .windows      (windows),
        .inbound_addr (req_reg.inbound_addr),
        .result       (match)
    );

    // Fields that mean nothing for a command are returned as zero; the
    // unused command code gives an all-zero response.
    always_comb
    begin
        rsp_next = '0;
        case (req_reg.command)
            oatu_pkg::CMD_READ:
            begin
                rsp_next.read_data = read_data;
            end
            oatu_pkg::CMD_XLATE:
            begin
                rsp_next.hit             = match.hit;
                rsp_next.hit_window      = match.hit_window;
                rsp_next.translated_addr = match.translated_addr;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (advance && req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `OATU_ASSERT_SAME(a_miss_is_zero, rsp_valid_reg && !rsp_reg.hit, rsp_reg.translated_addr == 64'd0 && rsp_reg.hit_window == 3'd0, "miss response carries a non-zero address or window")
    `OATU_ASSERT_SAME(a_hit_no_read_data, rsp_valid_reg && rsp_reg.hit, rsp_reg.read_data == 32'd0, "translate hit carries register read data")
    `OATU_ASSERT_NEXT(a_held_request, req_valid_reg && !advance, req_valid_reg && $stable(req_reg), "blocked request left the input register")

endmodule
